### design/dsil_pkg.sv
// shared types and constants for the descending sorted insert list
package dsil_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  // field widths fixed by the stream format
  localparam int DIST_W  = 32;
  localparam int RIDX_W  = 4;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // action codes carried in in_tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic compare;  // register the per-cell key compare flags
    logic commit;   // update the list and load the result register
  } dsil_cmd_t;

endpackage

### design/dsil_ctrl.sv
// controller state machine: sequences capture, compare and commit per item
module dsil_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output dsil_pkg::dsil_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.compare = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        // hold the list untouched until the result register can take the result
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/dsil_datapath.sv
// datapath: row of compare-and-shift cells, entry count and result register
module dsil_datapath #(
  parameter int CAPACITY = dsil_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = dsil_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dsil_pkg::dsil_cmd_t               cmd,
  input  logic                              in_action,
  input  logic [dsil_pkg::DIST_W-1:0]       in_distance,
  input  logic                              in_kind,
  input  logic [dsil_pkg::RIDX_W-1:0]       in_index,
  output logic [dsil_pkg::OUT_TDATA_W-1:0]  result
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > dsil_pkg::RIDX_W + 1) ? CNT_W : dsil_pkg::RIDX_W + 1;

  // latched transaction
  logic                        action_r;
  logic [KEY_BITS-1:0]         key_r;
  logic                        kind_r;
  logic [dsil_pkg::RIDX_W-1:0] index_r;

  // cells
  logic [KEY_BITS-1:0] cell_key_r  [CAPACITY];
  logic                cell_kind_r [CAPACITY];
  logic [CAPACITY-1:0] ge_r, ge_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic [CAPACITY-1:0] ins_hot;
  logic [CNT_W-1:0]    pos;
  logic                full;
  logic                do_insert;
  logic                rd_ok;
  logic [IDX_W-1:0]    rd_idx;

  logic [dsil_pkg::OUT_TDATA_W-1:0] result_r, result_nxt;

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign do_insert = cmd.commit && (action_r == dsil_pkg::ACT_INSERT) && !full;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      key_r    <= KEY_BITS'(in_distance);
      kind_r   <= in_kind;
      index_r  <= in_index;
    end
  end

  // a cell keeps its place when it is held and its key is not below the new key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_nxt[i] = (CNT_W'(i) < count_r) && (cell_key_r[i] >= key_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      ge_r <= ge_nxt;
    end
  end

  // the flags form a run of ones; the new entry goes at the first zero
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        ins_hot[i] = !ge_r[i];
      end else begin
        ins_hot[i] = !ge_r[i] && ge_r[i-1];
      end
      if (ins_hot[i]) begin
        pos = pos | CNT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (ins_hot[i]) begin
          cell_key_r[i]  <= key_r;
          cell_kind_r[i] <= kind_r;
        end else if (!ge_r[i] && i > 0) begin
          cell_key_r[i]  <= cell_key_r[(i > 0) ? i - 1 : 0];
          cell_kind_r[i] <= cell_kind_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  assign count_nxt = do_insert ? count_r + CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign rd_ok  = (CMP_W'(index_r) < CMP_W'(count_r)) && (CMP_W'(index_r) < CMP_W'(CAPACITY));
  assign rd_idx = IDX_W'(index_r);

  // result layout: accepted, insert_position, entry_count, read_valid,
  // read_distance, read_kind, zero fill
  always_comb begin
    result_nxt = '0;
    result_nxt[9:5] = dsil_pkg::COUNT_W'(count_nxt);
    if (action_r == dsil_pkg::ACT_INSERT) begin
      if (!full) begin
        result_nxt[0]   = 1'b1;
        result_nxt[4:1] = dsil_pkg::POS_W'(pos);
      end
    end else if (rd_ok) begin
      result_nxt[10]    = 1'b1;
      result_nxt[42:11] = dsil_pkg::DIST_W'(cell_key_r[rd_idx]);
      result_nxt[43]    = cell_kind_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

### design/descending_sorted_insert_list_top.sv
// Descending sorted insert list. Holds up to CAPACITY entries (a KEY_BITS key
// and a one-bit body kind) ordered from largest key to smallest in a row of
// compare-and-shift cells; an insert goes before the first entry with a
// strictly smaller key, so equal keys land after those already held, and an
// insert into a full list is refused with accepted low. A read returns the entry
// at read_index with read_valid. Every input transaction yields one result
// transaction. An item is first latched, then the compare of every cell against
// the new key is registered, then the cells shift and the result register loads;
// the next item is taken once the previous one has reached the result register,
// so a new item is not accepted while an earlier one is still being worked on;
// a result left waiting holds the next item in its last step.
module descending_sorted_insert_list_top #(
  parameter int CAPACITY = dsil_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = dsil_pkg::KEY_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // insert_distance[31:0], body_kind[32], read_index[36:33], zero fill
  input  logic [dsil_pkg::IN_TDATA_W-1:0]      in_tdata,
  // action[0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // accepted[0], insert_position[4:1], entry_count[9:5], read_valid[10],
  // read_distance[42:11], read_kind[43], zero fill
  output logic [dsil_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  dsil_pkg::dsil_cmd_t cmd;

  dsil_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dsil_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_action   (in_tuser),
    .in_distance (in_tdata[31:0]),
    .in_kind     (in_tdata[32]),
    .in_index    (in_tdata[36:33]),
    .result      (out_tdata)
  );

endmodule

### tb/descending_sorted_insert_list_top_tb.sv
// testbench for the descending sorted insert list: stream stimulus, list predictor, reply checks
`timescale 1ns / 100ps

module descending_sorted_insert_list_top_tb;

  localparam int LIST_DEPTH    = dsil_pkg::CAPACITY_DEF;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic                        action;
    logic [dsil_pkg::DIST_W-1:0] distance;
    logic                        kind;
    logic [dsil_pkg::RIDX_W-1:0] idx;
  } list_op_t;

  typedef struct packed {
    logic                         accepted;
    logic [dsil_pkg::POS_W-1:0]   position;
    logic [dsil_pkg::COUNT_W-1:0] count;
    logic                         read_valid;
    logic [dsil_pkg::DIST_W-1:0]  read_dist;
    logic                         read_kind;
  } list_reply_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [dsil_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tuser   = dsil_pkg::ACT_INSERT;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [dsil_pkg::OUT_TDATA_W-1:0] out_tdata;

  // predicted contents of the list
  logic [dsil_pkg::DIST_W-1:0] held_keys [LIST_DEPTH];
  logic                        held_kinds [LIST_DEPTH];
  int                          held_len = 0;
  list_reply_t                 expected_replies [$];

  bit sender_gaps     = 1'b0;
  bit receiver_stalls = 1'b0;
  bit long_hold_req   = 1'b0;

  int mismatches   = 0;
  int ops_sent     = 0;
  int replies_seen = 0;
  int n_stored     = 0;
  int n_refused    = 0;
  int n_reads      = 0;
  int n_read_hits  = 0;

  descending_sorted_insert_list_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  function automatic list_reply_t insert_or_read(list_op_t op);
    list_reply_t r;
    int p;
    r = '0;
    p = 0;
    if (op.action == dsil_pkg::ACT_INSERT) begin
      if (held_len < LIST_DEPTH) begin
        // equal keys stay ahead of the new entry
        while (p < held_len && held_keys[p] >= op.distance) p++;
        for (int i = held_len; i > p; i--) begin
          held_keys[i]  = held_keys[i-1];
          held_kinds[i] = held_kinds[i-1];
        end
        held_keys[p]  = op.distance;
        held_kinds[p] = op.kind;
        held_len++;
        r.accepted = 1'b1;
        r.position = p[dsil_pkg::POS_W-1:0];
        n_stored++;
      end else begin
        n_refused++;
      end
    end else begin
      n_reads++;
      if (op.idx < held_len) begin
        r.read_valid = 1'b1;
        r.read_dist  = held_keys[op.idx];
        r.read_kind  = held_kinds[op.idx];
        n_read_hits++;
      end
    end
    r.count = held_len[dsil_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function automatic string reply_text(list_reply_t r);
    return $sformatf("acc=%0d pos=%0d cnt=%0d rvalid=%0d rdist=%h rkind=%0d",
                     r.accepted, r.position, r.count, r.read_valid, r.read_dist, r.read_kind);
  endfunction

  function automatic list_op_t make_op(logic action, logic [dsil_pkg::DIST_W-1:0] distance,
                                       logic kind, logic [dsil_pkg::RIDX_W-1:0] idx);
    list_op_t op;
    op.action   = action;
    op.distance = distance;
    op.kind     = kind;
    op.idx      = idx;
    return op;
  endfunction

  function automatic list_op_t random_op(int insert_pct);
    list_op_t op;
    op.action = ($urandom_range(0, 99) < insert_pct) ? dsil_pkg::ACT_INSERT : dsil_pkg::ACT_READ;
    case ($urandom_range(0, 7))
      0: op.distance = '1;
      1: op.distance = '0;
      // reuse a held key to hit the equal-key ordering
      2: op.distance = (held_len > 0) ? held_keys[$urandom_range(0, held_len - 1)] : $urandom;
      default: op.distance = $urandom;
    endcase
    op.kind = 1'($urandom_range(0, 1));
    op.idx  = dsil_pkg::RIDX_W'($urandom_range(0, 15));
    return op;
  endfunction

  // predict on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_replies.push_back(insert_or_read(make_op(in_tuser, in_tdata[31:0],
                                                        in_tdata[32], in_tdata[36:33])));
  end

  always @(posedge clk) begin : check_replies
    list_reply_t got;
    list_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.accepted   = out_tdata[0];
      got.position   = out_tdata[4:1];
      got.count      = out_tdata[9:5];
      got.read_valid = out_tdata[10];
      got.read_dist  = out_tdata[42:11];
      got.read_kind  = out_tdata[43];
      replies_seen++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected reply at %0t: %s", $realtime, reply_text(got));
      end else begin
        want = expected_replies.pop_front();
        if (got.accepted !== want.accepted || got.position !== want.position ||
            got.count !== want.count || got.read_valid !== want.read_valid ||
            got.read_dist !== want.read_dist || got.read_kind !== want.read_kind) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("reply mismatch at %0t", $realtime);
            $display("  expected %s", reply_text(want));
            $display("  actual   %s", reply_text(got));
          end
        end
      end
    end
  end

  // result side ready control
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_op(list_op_t op);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op.action;
    in_tdata  <= {{(dsil_pkg::IN_TDATA_W-37){1'b0}}, op.idx, op.kind, op.distance};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ops_sent++;
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_seen < ops_sent) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    send_op(make_op(dsil_pkg::ACT_READ, '0, 1'b0, 4'd0));
    send_op(make_op(dsil_pkg::ACT_READ, '1, 1'b1, 4'd15));
    send_op(make_op(dsil_pkg::ACT_INSERT, 32'hFFFF_FFFF, 1'b1, 4'd0));
    send_op(make_op(dsil_pkg::ACT_INSERT, 32'h0000_0000, 1'b0, 4'd15));
    send_op(make_op(dsil_pkg::ACT_INSERT, 32'hFFFF_FFFF, 1'b0, 4'd0));
    send_op(make_op(dsil_pkg::ACT_INSERT, 32'h8000_0000, 1'b1, 4'd0));
    send_op(make_op(dsil_pkg::ACT_INSERT, 32'h7FFF_FFFF, 1'b0, 4'd0));
    send_op(make_op(dsil_pkg::ACT_INSERT, 32'h0000_0000, 1'b1, 4'd0));
    send_op(make_op(dsil_pkg::ACT_READ, '0, 1'b0, 4'd0));
    send_op(make_op(dsil_pkg::ACT_READ, '0, 1'b0, 4'd1));
    send_op(make_op(dsil_pkg::ACT_READ, '0, 1'b0, 4'd4));
    send_op(make_op(dsil_pkg::ACT_READ, '0, 1'b0, 4'd5));
    // reads past the held count
    send_op(make_op(dsil_pkg::ACT_READ, '0, 1'b0, 4'd6));
    send_op(make_op(dsil_pkg::ACT_READ, '1, 1'b1, 4'd15));
  endtask

  task automatic test_random_fill();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    repeat (250) send_op(random_op(6));
  endtask

  task automatic test_output_backpressure();
    // stall the result side long enough for in_tready to drop
    long_hold_req = 1'b1;
    repeat (12) send_op(random_op(6));
  endtask

  task automatic test_pause_until_drained();
    repeat (20) send_op(random_op(10));
    drain_replies();
    repeat (20) send_op(random_op(10));
  endtask

  task automatic test_full_list();
    list_op_t op;
    repeat (LIST_DEPTH) begin
      op = random_op(100);
      send_op(op);
    end
    send_op(make_op(dsil_pkg::ACT_INSERT, 32'hFFFF_FFFF, 1'b1, 4'd0));
    send_op(make_op(dsil_pkg::ACT_INSERT, 32'h0000_0000, 1'b0, 4'd15));
    send_op(make_op(dsil_pkg::ACT_READ, '0, 1'b0, 4'd15));
    send_op(make_op(dsil_pkg::ACT_READ, '0, 1'b0, 4'd0));
    // last stretch at full rate on both sides
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    repeat (300) send_op(random_op(30));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_random_fill();
    test_output_backpressure();
    test_pause_until_drained();
    test_full_list();

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      mismatches += expected_replies.size();
      $display("%0d replies never arrived", expected_replies.size());
    end

    $display("ran %0d transactions: %0d inserts stored, %0d refused on a full list",
             ops_sent, n_stored, n_refused);
    $display("%0d reads, %0d inside the held range; %0d mismatches",
             n_reads, n_read_hits, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
